### hw/rtl/crtp_pkg.sv
// ----------------------------------------------------------------------------
// crtp_pkg
// Shared types, constants and helper functions for the controller report
// text parser.
// ----------------------------------------------------------------------------
package crtp_pkg;

	localparam int unsigned FIELD_W    = 10;
	localparam int unsigned NUM_FIELDS = 7;
	localparam int unsigned COUNT_W    = 5;

	// A frame from the id digit through the closing bracket is this long.
	localparam logic [COUNT_W-1:0] FRAME_LEN = 5'd29;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
	localparam logic [FIELD_W-1:0] ACC_MAX   = 10'd999;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	typedef logic [2:0] fld_idx_t;

	localparam fld_idx_t FLD_X  = 3'd0;
	localparam fld_idx_t FLD_Y  = 3'd1;
	localparam fld_idx_t FLD_C  = 3'd2;
	localparam fld_idx_t FLD_Z  = 3'd3;
	localparam fld_idx_t FLD_AX = 3'd4;
	localparam fld_idx_t FLD_AY = 3'd5;
	localparam fld_idx_t FLD_AZ = 3'd6;

	typedef enum logic [3:0] {
		ST_SYNC = 4'd0,
		ST_ID   = 4'd1,
		ST_X    = 4'd2,
		ST_Y    = 4'd3,
		ST_C    = 4'd4,
		ST_Z    = 4'd5,
		ST_AX   = 4'd6,
		ST_AY   = 4'd7,
		ST_AZ   = 4'd8
	} parse_state_t;

	typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] rec_t;

	// Everything one character leaves on the result side.
	typedef struct packed {
		logic done;
		logic id;
		rec_t rec;
	} result_t;

	function automatic logic is_digit(input logic [7:0] ch);
		return ch inside {[CH_ZERO:CH_NINE]};
	endfunction

	// acc * 10 + digit, clamped to ACC_MAX. The digit value is the low nibble.
	function automatic logic [FIELD_W-1:0] acc_digit(input logic [FIELD_W-1:0] acc,
		input logic [7:0] ch);
		logic [13:0] v;
		v = ({4'd0, acc} * 14'd10) + {10'd0, ch[3:0]};
		return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[FIELD_W-1:0];
	endfunction

endpackage

### hw/rtl/controller_report_text_parser_core.sv
// ----------------------------------------------------------------------------
// controller_report_text_parser_core
// Parses text controller reports of the form id:[x,y] c z [ax,ay,az], one
// character per transaction, and reports the published record after each.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the output is not stalled by
// out_ready; the parser update for a character is a single pass through
// the step logic between the input and result registers.
// Reset (arst_n low, asynchronous): parser waits for line sync, accumulator,
// count, id and both records clear, and both pipeline stages empty.
// ----------------------------------------------------------------------------
module controller_report_text_parser_core (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       frame_done,
	output logic       controller_id,
	output logic [9:0] stick_x,
	output logic [9:0] stick_y,
	output logic [9:0] button_c,
	output logic [9:0] button_z,
	output logic [9:0] accel_x,
	output logic [9:0] accel_y,
	output logic [9:0] accel_z
);

	// Input stage: holds the accepted character until it moves into the result stage.
	logic              valid_s1;
	logic [7:0]        char_s1;

	// Result stage: the parser's answer for the character that left stage one.
	logic              valid_s2;
	crtp_pkg::result_t res_s2;

	crtp_pkg::result_t res_d;
	logic              adv_s1;

	// Stage one moves on whenever the result register is empty or is being
	// drained in this same cycle, so while a result waits, intake continues
	// only until the one slot in stage one is full.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	// The parser state advances exactly once per character, at the edge where
	// the character moves from the input stage into the result register.
	crtp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.ch      (char_s1),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign frame_done    = res_s2.done;
	assign controller_id = res_s2.id;
	assign stick_x       = res_s2.rec[crtp_pkg::FLD_X];
	assign stick_y       = res_s2.rec[crtp_pkg::FLD_Y];
	assign button_c      = res_s2.rec[crtp_pkg::FLD_C];
	assign button_z      = res_s2.rec[crtp_pkg::FLD_Z];
	assign accel_x       = res_s2.rec[crtp_pkg::FLD_AX];
	assign accel_y       = res_s2.rec[crtp_pkg::FLD_AY];
	assign accel_z       = res_s2.rec[crtp_pkg::FLD_AZ];

endmodule

### hw/rtl/crtp_parser.sv
// ----------------------------------------------------------------------------
// crtp_parser
// Parser state, decimal accumulator, character count, staged and published
// records. Advances by one character whenever step_en is high and presents
// the result of that character combinationally.
// ----------------------------------------------------------------------------
module crtp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  logic [7:0]             ch,
	output crtp_pkg::result_t      res
);

	crtp_pkg::parse_state_t            state_q, state_d;
	logic [crtp_pkg::FIELD_W-1:0]      acc_q, acc_d;
	logic [crtp_pkg::COUNT_W-1:0]      count_q, count_d, count_inc;
	crtp_pkg::rec_t                    staged_q, staged_d;
	crtp_pkg::rec_t                    pub_q, pub_d;
	logic                              id_q, id_d;
	logic                              done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= crtp_pkg::ST_SYNC;
			acc_q    <= '0;
			count_q  <= '0;
			staged_q <= '0;
			pub_q    <= '0;
			id_q     <= 1'b0;
		end else if (step_en) begin
			state_q  <= state_d;
			acc_q    <= acc_d;
			count_q  <= count_d;
			staged_q <= staged_d;
			pub_q    <= pub_d;
			id_q     <= id_d;
		end
	end

	assign count_inc = (count_q != crtp_pkg::COUNT_MAX) ? count_q + 5'd1 : count_q;

	always_comb begin
		state_d  = state_q;
		acc_d    = acc_q;
		count_d  = count_q;
		staged_d = staged_q;
		pub_d    = pub_q;
		id_d     = id_q;
		done     = 1'b0;

		if (ch == crtp_pkg::CH_NUL) begin
			state_d = crtp_pkg::ST_ID;
		end else begin
			count_d = count_inc;
			case (state_q)
				crtp_pkg::ST_SYNC: begin
					acc_d   = '0;
					count_d = '0;
					if (ch == crtp_pkg::CH_LF || ch == crtp_pkg::CH_RBRACK) begin
						state_d = crtp_pkg::ST_ID;
					end
				end
				crtp_pkg::ST_ID: begin
					if (ch == crtp_pkg::CH_LBRACK) begin
						state_d = crtp_pkg::ST_X;
					end else if (ch == crtp_pkg::CH_ONE || ch == crtp_pkg::CH_ZERO) begin
						id_d    = ch[0];
						count_d = 5'd1;
					end
				end
				crtp_pkg::ST_X, crtp_pkg::ST_AX, crtp_pkg::ST_AY: begin
					if (ch == crtp_pkg::CH_COMMA) begin
						case (state_q)
							crtp_pkg::ST_X: begin
								staged_d[crtp_pkg::FLD_X] = acc_q;
								state_d = crtp_pkg::ST_Y;
							end
							crtp_pkg::ST_AX: begin
								staged_d[crtp_pkg::FLD_AX] = acc_q;
								state_d = crtp_pkg::ST_AY;
							end
							default: begin
								staged_d[crtp_pkg::FLD_AY] = acc_q;
								state_d = crtp_pkg::ST_AZ;
							end
						endcase
						acc_d = '0;
					end else if (crtp_pkg::is_digit(ch)) begin
						acc_d = crtp_pkg::acc_digit(acc_q, ch);
					end
				end
				crtp_pkg::ST_Y: begin
					// The accumulator is kept: a button without a digit inherits it.
					if (ch == crtp_pkg::CH_SPACE) begin
						staged_d[crtp_pkg::FLD_Y] = acc_q;
						state_d = crtp_pkg::ST_C;
					end else if (crtp_pkg::is_digit(ch)) begin
						acc_d = crtp_pkg::acc_digit(acc_q, ch);
					end
				end
				crtp_pkg::ST_C: begin
					if (ch == crtp_pkg::CH_SPACE) begin
						staged_d[crtp_pkg::FLD_C] = acc_q;
						state_d = crtp_pkg::ST_Z;
					end else if (ch == crtp_pkg::CH_ONE || ch == crtp_pkg::CH_ZERO) begin
						acc_d = {9'd0, ch[0]};
					end
				end
				crtp_pkg::ST_Z: begin
					if (ch == crtp_pkg::CH_LBRACK) begin
						staged_d[crtp_pkg::FLD_Z] = acc_q;
						acc_d   = '0;
						state_d = crtp_pkg::ST_AX;
					end else if (ch == crtp_pkg::CH_ONE || ch == crtp_pkg::CH_ZERO) begin
						acc_d = {9'd0, ch[0]};
					end
				end
				crtp_pkg::ST_AZ: begin
					if (ch == crtp_pkg::CH_RBRACK) begin
						staged_d[crtp_pkg::FLD_AZ] = acc_q;
						if (count_inc == crtp_pkg::FRAME_LEN) begin
							pub_d = staged_d;
							done  = 1'b1;
						end
						acc_d   = '0;
						state_d = crtp_pkg::ST_ID;
					end else if (crtp_pkg::is_digit(ch)) begin
						acc_d = crtp_pkg::acc_digit(acc_q, ch);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.done = done;
	assign res.id   = id_d;
	assign res.rec  = pub_d;

endmodule
